// ===== rtl/core/rtmu_pkg.sv =====
// Shared types, constants and helpers of the route table metric update unit.
`timescale 1ns / 1ps
`default_nettype none

package rtmu_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int ADDR_W = 16;
  localparam int METRIC_W = 16;
  localparam int ENTRY_W = 4;
  localparam int STATUS_W = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [METRIC_W-1:0] metric_t;

  localparam idx_t IDX_LAST = idx_t'(TABLE_ENTRIES - 1);
  localparam addr_t NO_HOP = 16'hffff;
  localparam addr_t FREE_DEST = 16'h0000;
  localparam metric_t THRESHOLD_RESET = 16'd3000;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;

  typedef enum logic [STATUS_W-1:0] {
    ST_REFRESHED = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_KEPT      = 3'd2,
    ST_INSERTED  = 3'd3,
    ST_FULL      = 3'd4,
    ST_HIT       = 3'd5,
    ST_MISS      = 3'd6
  } status_e;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    logic free;
    idx_t free_idx;
  } scan_res_t;

  typedef struct packed {
    logic    we_dest;
    logic    we_metric;
    idx_t    addr;
    addr_t   dest;
    addr_t   hop;
    metric_t bat;
    metric_t sig;
  } tbl_wr_t;

  function automatic logic [ENTRY_W-1:0] to_entry(idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[ENTRY_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rtmu_table.sv =====
// Route table storage: destination column in flops, metrics in a registered-read memory.
`timescale 1ns / 1ps
`default_nettype none

module rtmu_table (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rtmu_pkg::idx_t    scan_idx_i,
  output rtmu_pkg::addr_t        dest_rd_o,
  input  wire rtmu_pkg::idx_t    rd_addr_i,
  output rtmu_pkg::addr_t        hop_rd_o,
  output rtmu_pkg::metric_t      bat_rd_o,
  output rtmu_pkg::metric_t      sig_rd_o,
  input  wire rtmu_pkg::tbl_wr_t wr_i
);

  rtmu_pkg::addr_t dest_q [rtmu_pkg::TABLE_ENTRIES];
  logic [3*rtmu_pkg::ADDR_W-1:0] mem_q [rtmu_pkg::TABLE_ENTRIES];
  logic [3*rtmu_pkg::ADDR_W-1:0] rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < rtmu_pkg::TABLE_ENTRIES; k++) begin
        dest_q[k] <= rtmu_pkg::FREE_DEST;
      end
    end else if (wr_i.we_dest) begin
      dest_q[wr_i.addr] <= wr_i.dest;
    end
  end

  assign dest_rd_o = dest_q[scan_idx_i];

  always_ff @(posedge clk_i) begin
    if (wr_i.we_metric) begin
      mem_q[wr_i.addr] <= {wr_i.sig, wr_i.bat, wr_i.hop};
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign hop_rd_o = rd_data_q[rtmu_pkg::ADDR_W-1:0];
  assign bat_rd_o = rd_data_q[2*rtmu_pkg::ADDR_W-1:rtmu_pkg::ADDR_W];
  assign sig_rd_o = rd_data_q[3*rtmu_pkg::ADDR_W-1:2*rtmu_pkg::ADDR_W];

endmodule

`default_nettype wire

// ===== rtl/core/rtmu_scan.sv =====
// Destination scanner: walks the table entry by entry, tracking first match and first free.
`timescale 1ns / 1ps
`default_nettype none

module rtmu_scan (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire rtmu_pkg::addr_t key_i,
  input  wire rtmu_pkg::addr_t dest_rd_i,
  output rtmu_pkg::idx_t       rd_idx_o,
  output logic                 done_o,
  output rtmu_pkg::scan_res_t  res_o
);

  logic busy_q;
  logic done_q;
  rtmu_pkg::idx_t idx_q;
  rtmu_pkg::scan_res_t res_q;
  logic match;
  logic empty;
  logic last;

  assign match = busy_q && (dest_rd_i == key_i);
  assign empty = busy_q && (dest_rd_i == rtmu_pkg::FREE_DEST);
  assign last  = (idx_q == rtmu_pkg::IDX_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
      res_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        res_q  <= '0;
      end else if (busy_q) begin
        if (match && !res_q.hit) begin
          res_q.hit     <= 1'b1;
          res_q.hit_idx <= idx_q;
        end
        if (empty && !res_q.free) begin
          res_q.free     <= 1'b1;
          res_q.free_idx <= idx_q;
        end
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  assign rd_idx_o = idx_q;
  assign done_o   = done_q;
  assign res_o    = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/route_table_metric_update_unit.sv =====
// Top level of the route table metric update unit: sequencer, config register, output stage.
//
// A transaction with a nonzero destination walks every table entry, also past a match.
// One that finds its destination then reads the entry's metrics before the decision; one
// that does not find it skips the metric read. A destination of zero skips the walk and
// goes straight to the emit state. s_axis_tready is high only while no transaction is in
// progress. It rises again in the cycle the result appears, so a new transaction is not
// accepted before the previous one has reached the output register. A finished result
// waits in the output register, so the next transaction can be accepted meanwhile.
// Update and lookup items share s_axis_tdata; tuser selects the operation.
`timescale 1ns / 1ps
`default_nettype none

module route_table_metric_update_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // destination[15:0], sender[31:16], battery_mv[47:32], signal_strength[63:48]
  input  wire logic [63:0] s_axis_tdata,
  // opcode[0]
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // next_hop[15:0], entry_index[19:16], zero[23:20]
  output logic [23:0]      m_axis_tdata,
  // status[2:0]
  output logic [2:0]       m_axis_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;

  rtmu_pkg::metric_t thresh_q;

  logic              op_q;
  rtmu_pkg::addr_t   dest_q;
  rtmu_pkg::addr_t   snd_q;
  rtmu_pkg::metric_t bat_q;
  rtmu_pkg::metric_t sig_q;

  rtmu_pkg::status_e                    res_status_q, res_status_d;
  rtmu_pkg::addr_t                      res_hop_q, res_hop_d;
  logic [rtmu_pkg::ENTRY_W-1:0]         res_idx_q, res_idx_d;

  logic                                 out_valid_q;
  rtmu_pkg::status_e                    out_status_q;
  rtmu_pkg::addr_t                      out_hop_q;
  logic [rtmu_pkg::ENTRY_W-1:0]         out_idx_q;

  logic in_acc;
  logic out_load;
  logic scan_start;
  logic scan_done;
  logic cfg_wr;
  rtmu_pkg::idx_t      scan_idx;
  rtmu_pkg::scan_res_t scan_res;
  rtmu_pkg::addr_t     dest_rd;
  rtmu_pkg::addr_t     hop_rd;
  rtmu_pkg::metric_t   bat_rd;
  rtmu_pkg::metric_t   sig_rd;
  rtmu_pkg::tbl_wr_t   tbl_wr;
  logic                better;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign scan_start    = in_acc && (s_axis_tdata[15:0] != rtmu_pkg::FREE_DEST);
  assign out_load      = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready);

  // config register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == rtmu_pkg::REG_THRESHOLD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= rtmu_pkg::THRESHOLD_RESET;
    end else if (cfg_wr) begin
      thresh_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == rtmu_pkg::REG_THRESHOLD) begin
      prdata = {16'h0000, thresh_q};
    end
  end

  rtmu_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .key_i     (dest_q),
    .dest_rd_i (dest_rd),
    .rd_idx_o  (scan_idx),
    .done_o    (scan_done),
    .res_o     (scan_res)
  );

  rtmu_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .scan_idx_i (scan_idx),
    .dest_rd_o  (dest_rd),
    .rd_addr_i  (scan_res.hit_idx),
    .hop_rd_o   (hop_rd),
    .bat_rd_o   (bat_rd),
    .sig_rd_o   (sig_rd),
    .wr_i       (tbl_wr)
  );

  assign better = (bat_q > thresh_q) ? (sig_q > sig_rd) : (bat_q > bat_rd);

  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    res_hop_d    = res_hop_q;
    res_idx_d    = res_idx_q;
    tbl_wr       = '0;
    tbl_wr.addr  = scan_res.hit_idx;
    tbl_wr.dest  = dest_q;
    tbl_wr.hop   = snd_q;
    tbl_wr.bat   = bat_q;
    tbl_wr.sig   = sig_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (scan_start) begin
            state_d = S_SCAN;
          end else begin
            // destination zero: nothing to find, nothing to store
            state_d      = S_EMIT;
            res_status_d = (s_axis_tuser[0] == rtmu_pkg::OP_LOOKUP) ?
                           rtmu_pkg::ST_MISS : rtmu_pkg::ST_KEPT;
            res_hop_d    = rtmu_pkg::NO_HOP;
            res_idx_d    = '0;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = scan_res.hit ? S_READ : S_DECIDE;
        end
      end
      S_READ: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d   = S_EMIT;
        res_hop_d = rtmu_pkg::NO_HOP;
        res_idx_d = '0;
        if (op_q == rtmu_pkg::OP_LOOKUP) begin
          if (scan_res.hit) begin
            res_status_d = rtmu_pkg::ST_HIT;
            res_hop_d    = hop_rd;
            res_idx_d    = rtmu_pkg::to_entry(scan_res.hit_idx);
          end else begin
            res_status_d = rtmu_pkg::ST_MISS;
          end
        end else if (scan_res.hit) begin
          res_idx_d = rtmu_pkg::to_entry(scan_res.hit_idx);
          if (hop_rd == snd_q) begin
            tbl_wr.we_metric = 1'b1;
            res_status_d     = rtmu_pkg::ST_REFRESHED;
            res_hop_d        = snd_q;
          end else if (better) begin
            tbl_wr.we_metric = 1'b1;
            res_status_d     = rtmu_pkg::ST_REPLACED;
            res_hop_d        = snd_q;
          end else begin
            res_status_d = rtmu_pkg::ST_KEPT;
            res_hop_d    = hop_rd;
          end
        end else if (scan_res.free) begin
          tbl_wr.addr      = scan_res.free_idx;
          tbl_wr.we_dest   = 1'b1;
          tbl_wr.we_metric = 1'b1;
          res_status_d     = rtmu_pkg::ST_INSERTED;
          res_hop_d        = snd_q;
          res_idx_d        = rtmu_pkg::to_entry(scan_res.free_idx);
        end else begin
          res_status_d = rtmu_pkg::ST_FULL;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tuser[0];
      dest_q <= s_axis_tdata[15:0];
      snd_q  <= s_axis_tdata[31:16];
      bat_q  <= s_axis_tdata[47:32];
      sig_q  <= s_axis_tdata[63:48];
    end
    res_status_q <= res_status_d;
    res_hop_q    <= res_hop_d;
    res_idx_q    <= res_idx_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_hop_q    <= res_hop_q;
      out_idx_q    <= res_idx_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'h0, out_idx_q, out_hop_q};
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

// ===== rtl/core/rtmu_checker.sv =====
// Port-level checker for the route table metric update unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rtmu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a transaction is in progress");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= rtmu_pkg::ST_MISS))
    else $error("status code out of range");

  a_no_route_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == rtmu_pkg::ST_FULL || m_axis_tuser == rtmu_pkg::ST_MISS)
    |-> (m_axis_tdata[15:0] == rtmu_pkg::NO_HOP) && (m_axis_tdata[19:16] == 4'h0))
    else $error("full or miss result carries a route");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
    |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind route_table_metric_update_unit rtmu_checker u_rtmu_checker (.*);

`default_nettype wire

// ===== sim/route_table_metric_update_unit_checker.sv =====
// Checker for the route table metric update unit: table predictor and result comparison.
`timescale 1ns / 1ps

module route_table_metric_update_unit_checker
  import rtmu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  // destination[15:0], sender[31:16], battery_mv[47:32], signal_strength[63:48]
  input  wire logic [63:0] s_axis_tdata,
  // opcode[0]
  input  wire logic [0:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // next_hop[15:0], entry_index[19:16], zero[23:20]
  input  wire logic [23:0] m_axis_tdata,
  // status[2:0]
  input  wire logic [2:0]  m_axis_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               mismatch_count_o,
  output int               pending_o,
  output int               checked_o,
  output logic [6:0]       status_seen_o
);

  typedef struct packed {
    status_e              status;
    addr_t                hop;
    logic [ENTRY_W-1:0]   entry;
  } route_verdict_t;

  addr_t   tbl_dest [TABLE_ENTRIES];
  addr_t   tbl_hop  [TABLE_ENTRIES];
  metric_t tbl_bat  [TABLE_ENTRIES];
  metric_t tbl_sig  [TABLE_ENTRIES];
  metric_t threshold;

  route_verdict_t route_verdicts_q[$];
  route_verdict_t want;
  int             mismatches = 0;
  int             checked = 0;
  logic [6:0]     seen = '0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = route_verdicts_q.size();
  assign checked_o        = checked;
  assign status_seen_o    = seen;

  function automatic int first_slot(addr_t key);
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (tbl_dest[k] == key) return k;
    end
    return -1;
  endfunction

  function automatic route_verdict_t resolve_route_item(logic op, addr_t dest, addr_t snd,
                                                        metric_t bat, metric_t sig);
    route_verdict_t v;
    int             k;
    logic           better;
    v.status = ST_KEPT;
    v.hop    = NO_HOP;
    v.entry  = '0;
    if (op == OP_LOOKUP) begin
      // free entries never count as routes
      k = (dest == FREE_DEST) ? -1 : first_slot(dest);
      if (k >= 0) begin
        v.status = ST_HIT;
        v.hop    = tbl_hop[k];
        v.entry  = ENTRY_W'(k);
      end else begin
        v.status = ST_MISS;
      end
    end else if (dest != FREE_DEST) begin
      k = first_slot(dest);
      if (k >= 0) begin
        if (tbl_hop[k] == snd) begin
          tbl_bat[k] = bat;
          tbl_sig[k] = sig;
          v.status   = ST_REFRESHED;
        end else begin
          better = (bat > threshold) ? (sig > tbl_sig[k]) : (bat > tbl_bat[k]);
          if (better) begin
            tbl_hop[k] = snd;
            tbl_bat[k] = bat;
            tbl_sig[k] = sig;
            v.status   = ST_REPLACED;
          end else begin
            v.status = ST_KEPT;
          end
        end
        v.hop   = tbl_hop[k];
        v.entry = ENTRY_W'(k);
      end else begin
        k = first_slot(FREE_DEST);
        if (k >= 0) begin
          tbl_dest[k] = dest;
          tbl_hop[k]  = snd;
          tbl_bat[k]  = bat;
          tbl_sig[k]  = sig;
          v.status    = ST_INSERTED;
          v.hop       = snd;
          v.entry     = ENTRY_W'(k);
        end else begin
          v.status = ST_FULL;
        end
      end
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        tbl_dest[k] = FREE_DEST;
        tbl_hop[k]  = NO_HOP;
        tbl_bat[k]  = '0;
        tbl_sig[k]  = '0;
      end
      threshold = THRESHOLD_RESET;
      route_verdicts_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_THRESHOLD)
        threshold = pwdata[METRIC_W-1:0];
      if (m_axis_tvalid && m_axis_tready) begin
        checked++;
        if (route_verdicts_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: status %0d hop %h entry %0d",
                   $time, m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[19:16]);
        end else begin
          want = route_verdicts_q.pop_front();
          seen[int'(want.status)] = 1'b1;
          if (m_axis_tuser !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
          end
          if (m_axis_tdata[15:0] !== want.hop) begin
            mismatches++;
            $display("%0t: next_hop expected %h actual %h", $time, want.hop,
                     m_axis_tdata[15:0]);
          end
          if (m_axis_tdata[19:16] !== want.entry) begin
            mismatches++;
            $display("%0t: entry_index expected %0d actual %0d", $time, want.entry,
                     m_axis_tdata[19:16]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        route_verdicts_q.push_back(resolve_route_item(s_axis_tuser[0], s_axis_tdata[15:0],
                                                      s_axis_tdata[31:16], s_axis_tdata[47:32],
                                                      s_axis_tdata[63:48]));
    end
  end

endmodule

// ===== sim/route_table_metric_update_unit_tb.sv =====
// Testbench top for the route table metric update unit: stimulus, handshake pacing, verdict.
`timescale 1ns / 1ps

module route_table_metric_update_unit_tb;
  import rtmu_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 220;
  localparam int DEST_POOL_N  = 20;
  localparam int HOP_POOL_N   = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int         mismatches;
  int         pending;
  int         checked;
  logic [6:0] status_seen;

  logic    steady = 1'b0;
  metric_t thr = THRESHOLD_RESET;
  addr_t   dest_pool [DEST_POOL_N];
  addr_t   hop_pool  [HOP_POOL_N];
  int      items_driven = 0;
  int      stalled_cycles = 0;

  always #5 clk_i = ~clk_i;

  route_table_metric_update_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  route_table_metric_update_unit_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked),
    .status_seen_o    (status_seen)
  );

  // result side back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 26);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic drive_route_item(input logic op, input addr_t dest, input addr_t snd,
                                  input metric_t bat, input metric_t sig);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tuser  <= op;
    s_axis_tdata  <= {sig, bat, snd, dest};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_driven++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_threshold(input metric_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_THRESHOLD;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    thr = value;
  endtask

  task automatic random_route_item();
    int      pick;
    int      level;
    logic    op;
    addr_t   dest;
    addr_t   snd;
    metric_t bat;
    metric_t sig;
    op   = ($urandom_range(99) < 30) ? OP_LOOKUP : OP_UPDATE;
    pick = $urandom_range(99);
    if (pick < 4) dest = FREE_DEST;
    else if (pick < 16) dest = 16'($urandom);
    else dest = dest_pool[$urandom_range(DEST_POOL_N - 1)];
    snd  = ($urandom_range(99) < 65) ? hop_pool[$urandom_range(HOP_POOL_N - 1)]
                                     : 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      // hover around the threshold to hit both sides and equality
      level = int'(thr) + int'($urandom_range(4)) - 2;
      if (level < 0) level = 0;
      if (level > 65535) level = 65535;
      bat = 16'(level);
    end else if (pick < 55) begin
      bat = pick[0] ? 16'hffff : 16'h0000;
    end else begin
      bat = 16'($urandom);
    end
    if ($urandom_range(9) == 0) sig = $urandom_range(1) ? 16'hffff : 16'h0000;
    else sig = 16'($urandom);
    drive_route_item(op, dest, snd, bat, sig);
  endtask

  initial begin
    metric_t phase_thr [PHASES];
    addr_t   dst_a;
    addr_t   hop_a;
    addr_t   hop_b;
    dest_pool[0] = 16'h0001;
    dest_pool[1] = 16'hffff;
    for (int i = 2; i < DEST_POOL_N; i++) dest_pool[i] = 16'($urandom_range(65534, 2));
    hop_pool[0] = 16'h0000;
    hop_pool[1] = 16'hffff;
    for (int i = 2; i < HOP_POOL_N; i++) hop_pool[i] = 16'($urandom_range(65534, 1));
    phase_thr[0] = 16'd0;
    phase_thr[1] = 16'hffff;
    phase_thr[2] = THRESHOLD_RESET;
    phase_thr[3] = 16'($urandom);
    phase_thr[4] = 16'($urandom_range(6000, 500));
    dst_a = dest_pool[2];
    hop_a = hop_pool[2];
    hop_b = hop_pool[3];

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed pass at the reset threshold
    drive_route_item(OP_LOOKUP, FREE_DEST, 16'($urandom), 16'($urandom), 16'($urandom));
    drive_route_item(OP_UPDATE, FREE_DEST, 16'($urandom), 16'($urandom), 16'($urandom));
    drive_route_item(OP_LOOKUP, dst_a, 16'($urandom), 16'($urandom), 16'($urandom));
    drive_route_item(OP_UPDATE, dst_a, hop_a, 16'd0, 16'd0);
    drive_route_item(OP_UPDATE, dst_a, hop_a, 16'hffff, 16'hffff);
    drive_route_item(OP_UPDATE, dst_a, hop_b, THRESHOLD_RESET, 16'd0);
    drive_route_item(OP_UPDATE, dst_a, hop_b, THRESHOLD_RESET + 16'd1, 16'hffff);
    drive_route_item(OP_UPDATE, dst_a, hop_a, 16'd100, 16'd100);
    drive_route_item(OP_UPDATE, dst_a, hop_b, THRESHOLD_RESET, 16'd0);
    drive_route_item(OP_UPDATE, dst_a, hop_a, THRESHOLD_RESET + 16'd1, 16'd101);
    drive_route_item(OP_LOOKUP, dst_a, 16'd0, 16'd0, 16'd0);
    drive_route_item(OP_UPDATE, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    drive_route_item(OP_UPDATE, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    drive_route_item(OP_LOOKUP, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    drive_route_item(OP_UPDATE, 16'h0001, 16'h0000, 16'h1234, 16'h00ff);
    drive_route_item(OP_UPDATE, 16'hffff, 16'hfffe, 16'hffff, 16'h0000);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_threshold(phase_thr[p]);
      steady <= (p == 2);
      repeat (PHASE_ITEMS) random_route_item();
    end

    drain_results();
    steady <= 1'b0;
    repeat (40) @(posedge clk_i);
    $display("Drove %0d route transactions over %0d threshold settings (0 and 65535 included).",
             items_driven, PHASES + 1);
    $display("Checked %0d results; status codes seen (bit per code): %b.", checked,
             status_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
